@@ rtl/upp_pkg.sv @@
// ----------------------------------------------------------------------------
// upp_pkg: shared types and constants of the payload packetizer
// Beat structs for both channels, the command passed from the classifier
// to the header sequencer, and the fixed header codes.
// ----------------------------------------------------------------------------
package upp_pkg;

	localparam int REQ_CFG_W  = 11;
	localparam int MAXP_W     = 24;
	localparam int FRAME_W    = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_REQUEST_BYTES     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD_BYTES = 1'b1;

	localparam logic [REQ_CFG_W-1:0] REQ_BYTES_RESET = 11'd512;
	localparam logic [MAXP_W-1:0]    MAXP_RESET      = 24'd0;

	localparam logic [7:0] HDR_LENGTH = 8'h02;
	localparam logic [7:0] HDR_EOH    = 8'h80;
	localparam logic [7:0] HDR_EOF    = 8'h02;

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	typedef struct packed {
		logic [7:0]         pixel_byte;
		logic [FRAME_W-1:0] frame_bytes;
	} upp_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       request_last;
		logic       request_zero;
		logic       frame_end;
	} upp_out_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       hdr;
		logic [7:0] hdr_flags;
		logic       request_last;
		logic       request_zero;
		logic       frame_end;
	} upp_cmd_t;

	typedef enum logic [1:0] {
		BK_HEAD,
		BK_FLAGS,
		BK_PIXEL
	} back_state_t;

endpackage

@@ rtl/upp_fifo.sv @@
// ----------------------------------------------------------------------------
// upp_fifo: small register queue
// First-word-fall-through queue with registered count; full and empty
// come straight from the count.
// ----------------------------------------------------------------------------
module upp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

@@ rtl/upp_front.sv @@
// ----------------------------------------------------------------------------
// upp_front: frame and request classifier
// Holds the configuration and the frame, payload and request counters;
// decides per byte whether a header opens the request and where it ends.
// ----------------------------------------------------------------------------
module upp_front #(
	parameter int COUNT_WIDTH = 24,
	parameter int MAX_REQUEST = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [upp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [upp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                push,
	input  upp_pkg::upp_in_t                    in_beat,
	input  logic                                cmd_full,
	output logic                                cmd_push,
	output upp_pkg::upp_cmd_t                   cmd
);

	import upp_pkg::*;

	localparam int CW    = COUNT_WIDTH;
	localparam int RW    = $clog2(MAX_REQUEST + 1);
	localparam int CMP_W = (CW > MAXP_W) ? CW : MAXP_W;

	logic [REQ_CFG_W-1:0] req_cfg_q;
	logic [MAXP_W-1:0]    maxp_cfg_q;
	logic [CW-1:0]        fpos_q;
	logic [CW-1:0]        pcnt_q;
	logic [RW-1:0]        rpos_q;
	logic                 toggle_q;

	logic                 accept;
	logic [RW-1:0]        rsize;
	logic [MAXP_W-1:0]    maxp;
	logic                 bulk;
	logic [CW-1:0]        fsize_raw;
	logic [CW-1:0]        fsize;
	logic [CW-1:0]        remaining;
	logic                 last_of_frame;
	logic                 eof;
	logic                 hdr;
	logic [RW-1:0]        rpos_inc;
	logic [CW-1:0]        pcnt_inc;
	logic                 pl_full;
	logic                 req_end;

	assign accept   = push && !cmd_full;
	assign cmd_push = accept;

	always_comb begin
		if (req_cfg_q < REQ_CFG_W'(3)) begin
			rsize = RW'(3);
		end else if (req_cfg_q > REQ_CFG_W'(MAX_REQUEST)) begin
			rsize = RW'(MAX_REQUEST);
		end else begin
			rsize = req_cfg_q[RW-1:0];
		end
		bulk = (maxp_cfg_q != '0);
		maxp = (maxp_cfg_q < MAXP_W'(3)) ? MAXP_W'(3) : maxp_cfg_q;

		fsize_raw     = CW'(in_beat.frame_bytes);
		fsize         = (fsize_raw == '0) ? CW'(1) : fsize_raw;
		remaining     = (fpos_q < fsize) ? (fsize - fpos_q) : CW'(1);
		last_of_frame = (remaining == CW'(1));
		eof           = (remaining <= CW'(rsize - RW'(2)));

		hdr      = (rpos_q == '0) && (!bulk || (pcnt_q == '0));
		rpos_inc = (hdr ? RW'(2) : rpos_q) + RW'(1);
		pcnt_inc = ((hdr && bulk) ? CW'(2) : pcnt_q) + CW'(1);
		pl_full  = bulk && (CMP_W'(pcnt_inc) >= CMP_W'(maxp));
		req_end  = (rpos_inc >= rsize) || pl_full || last_of_frame;

		cmd.pixel_byte   = in_beat.pixel_byte;
		cmd.hdr          = hdr;
		cmd.hdr_flags    = HDR_EOH | {7'd0, toggle_q} | (eof ? HDR_EOF : 8'd0);
		cmd.request_last = req_end;
		cmd.request_zero = pl_full;
		cmd.frame_end    = last_of_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_cfg_q  <= REQ_BYTES_RESET;
			maxp_cfg_q <= MAXP_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_REQUEST_BYTES: begin
					req_cfg_q <= cfg_wdata[REQ_CFG_W-1:0];
				end
				REG_MAX_PAYLOAD_BYTES: begin
					maxp_cfg_q <= cfg_wdata[MAXP_W-1:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpos_q   <= '0;
			pcnt_q   <= '0;
			rpos_q   <= '0;
			toggle_q <= 1'b0;
		end else if (accept) begin
			rpos_q <= req_end ? '0 : rpos_inc;
			if (last_of_frame) begin
				fpos_q   <= '0;
				pcnt_q   <= '0;
				toggle_q <= !toggle_q;
			end else begin
				fpos_q <= fpos_q + CW'(1);
				if (bulk) begin
					pcnt_q <= pl_full ? '0 : pcnt_inc;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_rpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rpos_q < RW'(MAX_REQUEST))
		else $error("request position past request size");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_of_frame |=> (fpos_q == '0) && (rpos_q == '0) && (pcnt_q == '0))
		else $error("counters not cleared at frame end");
`endif

endmodule

@@ rtl/upp_back.sv @@
// ----------------------------------------------------------------------------
// upp_back: header sequencer
// Expands each command into its beats: two header beats when the command
// opens a payload, then the data beat with its end flags.
// ----------------------------------------------------------------------------
module upp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	input  upp_pkg::upp_cmd_t cmd,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output upp_pkg::upp_out_t res
);

	import upp_pkg::*;

	back_state_t state_q;
	back_state_t state_d;
	logic        go;

	assign go = !cmd_empty && !res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_HEAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		res_push = go;
		res.out_byte     = cmd.pixel_byte;
		res.request_last = cmd.request_last;
		res.request_zero = cmd.request_zero;
		res.frame_end    = cmd.frame_end;
		unique case (state_q)
			BK_HEAD: begin
				if (cmd.hdr) begin
					res.out_byte     = HDR_LENGTH;
					res.request_last = 1'b0;
					res.request_zero = 1'b0;
					res.frame_end    = 1'b0;
					if (go) begin
						state_d = BK_FLAGS;
					end
				end else begin
					cmd_pop = go;
				end
			end
			BK_FLAGS: begin
				res.out_byte     = cmd.hdr_flags;
				res.request_last = 1'b0;
				res.request_zero = 1'b0;
				res.frame_end    = 1'b0;
				if (go) begin
					state_d = BK_PIXEL;
				end
			end
			BK_PIXEL: begin
				cmd_pop = go;
				if (go) begin
					state_d = BK_HEAD;
				end
			end
		endcase
	end

`ifndef SYNTHESIS
	a_hdr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_FLAGS || state_q == BK_PIXEL) |-> !cmd_empty && cmd.hdr)
		else $error("header phase without a header command");

	a_pop_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_FLAGS |-> !cmd_pop)
		else $error("command dropped before its data beat");
`endif

endmodule

@@ rtl/uvc_payload_packetizer.sv @@
// ----------------------------------------------------------------------------
// uvc_payload_packetizer: video frame bytes to USB request beats
// Top level: classifier, command queue, header sequencer, result queue.
// ----------------------------------------------------------------------------
// Each frame byte pushed in comes out as one data beat; a beat that opens a
// request (every request in isochronous mode, max_payload_bytes == 0, or
// only the first request of each bulk payload) is preceded by two header
// beats, 0x02 and 0x80 | FID with EOF (0x02) set when the rest of the frame
// fits in the request. The input side takes one byte per cycle while the
// four-entry command queue has room; the output side delivers one beat per
// cycle while the sink pops, so a request of N data bytes with a header
// leaves as N + 2 beats and a header-less one as N. The result port is the
// single-beat-per-cycle bottleneck: the front runs ahead into the command
// queue and only stalls (full high) when header beats or a stalled sink have
// backed it up. A pushed byte reaches the output through the command queue
// and then the result queue, both registered.
// request_last marks the final beat of a request, request_zero marks a bulk
// payload ending exactly full, frame_end marks the last byte of the frame,
// at which the FID toggles and all counters clear. Configuration writes take
// effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module uvc_payload_packetizer #(
	parameter int COUNT_WIDTH = 24,
	parameter int MAX_REQUEST = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [upp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [upp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           push,
	output logic                           full,
	input  upp_pkg::upp_in_t               in_beat,
	input  logic                           pop,
	output logic                           empty,
	output upp_pkg::upp_out_t              out_beat
);

	import upp_pkg::*;

	upp_cmd_t cmd_wr;
	upp_cmd_t cmd_rd;
	upp_out_t res_wr;
	logic     cmd_push;
	logic     cmd_full;
	logic     cmd_pop;
	logic     cmd_empty;
	logic     res_push;
	logic     res_full;

	// Classify each byte and advance the frame, payload and request counters.
	upp_front #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.MAX_REQUEST(MAX_REQUEST)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.in_beat  (in_beat),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_wr)
	);

	// Decouple the classifier from header insertion.
	upp_fifo #(
		.WIDTH($bits(upp_cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_wr),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_rd),
		.empty (cmd_empty)
	);

	assign full = cmd_full;

	// Expand commands into header and data beats.
	upp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_rd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_wr)
	);

	// Hold finished beats so the sequencer keeps going while the sink stalls.
	upp_fifo #(
		.WIDTH($bits(upp_out_t)),
		.DEPTH(OUT_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_wr),
		.full  (res_full),
		.pop   (pop),
		.rdata (out_beat),
		.empty (empty)
	);

`ifndef SYNTHESIS
	a_zero_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_beat.request_zero |-> out_beat.request_last)
		else $error("zero flag on a beat that does not end a request");

	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_beat.frame_end |-> out_beat.request_last)
		else $error("frame end without request end");
`endif

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the UVC payload packetizer
// Streams video frame bytes through the packetizer under several request and
// bulk payload settings, predicts every header and data beat in a scoreboard
// class, and checks each popped beat against the oldest prediction; for most
// of the run both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import upp_pkg::*;

	class packet_scoreboard;
		localparam int MAX_REQUEST = 1024;

		// register copies
		logic [REQ_CFG_W-1:0] req_bytes;
		logic [MAXP_W-1:0]    payload_max;
		// packetizer state
		logic [FRAME_W-1:0]   frame_pos;
		logic [FRAME_W-1:0]   pay_cnt;
		logic [REQ_CFG_W-1:0] req_pos;
		logic                 fid;

		upp_out_t beats_due[$];
		int       mismatches;

		function new();
			req_bytes   = REQ_BYTES_RESET;
			payload_max = MAXP_RESET;
			frame_pos   = '0;
			pay_cnt     = '0;
			req_pos     = '0;
			fid         = 1'b0;
			mismatches  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_REQUEST_BYTES:     req_bytes = data[REQ_CFG_W-1:0];
				REG_MAX_PAYLOAD_BYTES: payload_max = data[MAXP_W-1:0];
				default: ;
			endcase
		endfunction

		// Work out the beats one accepted frame byte produces.
		function void note_byte(upp_in_t b);
			logic [REQ_CFG_W-1:0] rsize;
			logic [MAXP_W-1:0]    maxp;
			logic [FRAME_W-1:0]   fsize;
			logic [FRAME_W-1:0]   left;
			logic [7:0]           flags;
			logic                 bulk;
			logic                 frame_last;
			logic                 pay_full;
			logic                 req_end;
			rsize = req_bytes;
			if (rsize < 3)
				rsize = 3;
			if (rsize > MAX_REQUEST)
				rsize = MAX_REQUEST;
			bulk = payload_max != 0;
			maxp = payload_max;
			if (bulk && maxp < 3)
				maxp = 3;
			fsize = (b.frame_bytes == 0) ? 1 : b.frame_bytes;
			left = (frame_pos < fsize) ? fsize - frame_pos : 1;
			frame_last = left == 1;

			if (req_pos == 0 && (!bulk || pay_cnt == 0)) begin
				flags = HDR_EOH | {7'd0, fid};
				if (left <= rsize - 2)
					flags = flags | HDR_EOF;
				beats_due.push_back('{HDR_LENGTH, 1'b0, 1'b0, 1'b0});
				beats_due.push_back('{flags, 1'b0, 1'b0, 1'b0});
				req_pos = 2;
				if (bulk)
					pay_cnt = 2;
			end

			req_pos = req_pos + 1;
			frame_pos = frame_pos + 1;
			pay_full = 1'b0;
			if (bulk) begin
				pay_cnt = pay_cnt + 1;
				pay_full = pay_cnt >= maxp;
			end
			req_end = req_pos >= rsize || pay_full || frame_last;
			beats_due.push_back('{b.pixel_byte, req_end, req_end && pay_full, frame_last});

			if (req_end)
				req_pos = '0;
			if (bulk && pay_full)
				pay_cnt = '0;
			if (frame_last) begin
				fid = ~fid;
				frame_pos = '0;
				pay_cnt = '0;
				req_pos = '0;
			end
		endfunction

		function void check_beat(upp_out_t got);
			upp_out_t want;
			if (beats_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: byte %02h last %b zero %b fend %b",
						got.out_byte, got.request_last, got.request_zero, got.frame_end);
				return;
			end
			want = beats_due.pop_front();
			if (got.out_byte !== want.out_byte || got.request_last !== want.request_last ||
					got.request_zero !== want.request_zero ||
					got.frame_end !== want.frame_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("beat mismatch: byte %02h/%02h last %b/%b zero %b/%b fend %b/%b",
						want.out_byte, got.out_byte, want.request_last, got.request_last,
						want.request_zero, got.request_zero, want.frame_end, got.frame_end);
			end
		endfunction

		function int pending();
			return beats_due.size();
		endfunction
	endclass

	localparam int LONG_HOLD     = 90;   // receiver hold-off that backs the block up
	localparam int SETTLE_CYCLES = 6;    // quiet cycles before a register write
	localparam int TAIL_CYCLES   = 20;   // quiet cycles after the last beat
	localparam int STALL_LIMIT   = 1500; // cycles with no handshake before giving up

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  push;
	logic                  full;
	upp_in_t               in_beat;
	logic                  pop;
	logic                  empty;
	upp_out_t              out_beat;

	packet_scoreboard sb = new();

	// random idling switches, cleared for the last stretch of the run
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	// long receiver hold-off requests: the stimulus asks, the receiver serves
	int hold_asks   = 0;
	int hold_served = 0;
	int quiet_cycles = 0;

	// frame generator state
	logic [FRAME_W-1:0] cur_frame_bytes;
	int                 sent_in_frame;

	uvc_payload_packetizer #(
		.COUNT_WIDTH(FRAME_W),
		.MAX_REQUEST(1024)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.full     (full),
		.in_beat  (in_beat),
		.pop      (pop),
		.empty    (empty),
		.out_beat (out_beat)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Result side: pop at will, with random stall bursts and one long hold.
	// ------------------------------------------------------------------------
	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_asks != hold_served) begin
				// hold off long enough for the command and result queues to fill
				hold_served++;
				pop <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(0, 12)) @(posedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Check every beat taken off the result side.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_beat(out_beat);
	end

	// Watchdog: count cycles in which neither side hands over a beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// Offer one byte, hold it until the block takes it, then maybe pause.
	task automatic send_beat(upp_in_t b);
		push <= 1'b1;
		in_beat <= b;
		do
			@(posedge clk);
		while (full);
		sb.note_byte(b);
		if (tx_idle_on && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Send count random bytes all tagged with the same frame size.
	task automatic send_frame(logic [FRAME_W-1:0] fb, int count);
		upp_in_t b;
		for (int i = 0; i < count; i++) begin
			b.pixel_byte = $urandom_range(0, 255);
			b.frame_bytes = fb;
			send_beat(b);
		end
	endtask

	// Drain, let the block settle, then write one register.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic configure(logic [REQ_CFG_W-1:0] req, logic [MAXP_W-1:0] maxp);
		write_reg(REG_REQUEST_BYTES, CFG_DATA_W'(req));
		write_reg(REG_MAX_PAYLOAD_BYTES, maxp);
	endtask

	// Mostly short frames; now and then a zero or a full-width size.
	function automatic logic [FRAME_W-1:0] pick_frame_bytes();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return FRAME_W'($urandom);
			2, 3:    return FRAME_W'($urandom_range(1, 3));
			default: return FRAME_W'($urandom_range(1, 60));
		endcase
	endfunction

	// Random request size: mostly small, sometimes clamped from either side.
	function automatic logic [REQ_CFG_W-1:0] pick_request_bytes();
		case ($urandom_range(0, 9))
			0, 1:    return REQ_CFG_W'($urandom_range(0, 2));
			2:       return REQ_CFG_W'(1024);
			3:       return REQ_CFG_W'($urandom_range(1025, 2047));
			default: return REQ_CFG_W'($urandom_range(3, 48));
		endcase
	endfunction

	// Random payload size: isochronous, tiny, huge, or a workable bulk size.
	function automatic logic [MAXP_W-1:0] pick_payload_bytes();
		case ($urandom_range(0, 9))
			0, 1, 2: return '0;
			3:       return MAXP_W'($urandom_range(1, 2));
			4:       return '1;
			5:       return MAXP_W'($urandom);
			default: return MAXP_W'($urandom_range(3, 64));
		endcase
	endfunction

	// Stream well-formed frames with random content; once in a while swap the
	// frame size mid-frame so that a shrunk frame ends early.
	task automatic stream_frames(int count);
		upp_in_t            b;
		logic [FRAME_W-1:0] eff;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 39) == 0)
				cur_frame_bytes = pick_frame_bytes();
			b.pixel_byte = $urandom_range(0, 255);
			b.frame_bytes = cur_frame_bytes;
			send_beat(b);
			eff = (cur_frame_bytes == 0) ? 1 : cur_frame_bytes;
			sent_in_frame++;
			if (sent_in_frame >= eff) begin
				sent_in_frame = 0;
				cur_frame_bytes = pick_frame_bytes();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_REQUEST_BYTES;
		cfg_wdata <= '0;
		push <= 1'b0;
		in_beat <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Isochronous, five-byte requests: one-byte frame, zero frame size,
		// a frame split over two requests with EOF on the second header, then
		// a huge frame cut short by a smaller size.
		configure(11'd5, '0);
		send_beat(upp_in_t'{8'h00, 24'd1});
		send_beat(upp_in_t'{8'hFF, 24'd0});
		send_frame(24'd5, 5);
		send_frame(24'hFF_FFFF, 2);
		send_frame(24'd2, 1);

		// Request size below the floor and a tiny bulk payload: every data
		// byte fills its payload and raises the zero flag.
		configure(11'd0, 24'd1);
		send_frame(24'd4, 4);

		// Request size above the ceiling, largest payload.
		configure(11'd2047, 24'hFF_FFFF);
		send_frame(24'd3, 3);

		// Bulk payload spanning two requests, the second ending exactly full.
		configure(11'd6, 24'd10);
		send_frame(24'd10, 10);

		// Random phases: new settings each time, frames left mid-flight so
		// that a change can land inside a request or payload.
		sent_in_frame = 0;
		cur_frame_bytes = pick_frame_bytes();
		for (int phase = 0; phase < 8; phase++) begin
			configure(pick_request_bytes(), pick_payload_bytes());
			if (phase == 2)
				hold_asks++;
			stream_frames($urandom_range(35, 55));
		end

		// Last stretch at full rate on both sides.
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		configure(REQ_CFG_W'($urandom_range(3, 20)), MAXP_W'($urandom_range(3, 30)));
		stream_frames(40);

		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
